// ===== hw/rtl/isc_pkg.sv =====
package isc_pkg;

   // Register map, one register per 32-bit word.
   typedef enum logic [2:0] {
      REG_MODE           = 3'd0,
      REG_KEY_TYPE       = 3'd1,
      REG_OFFSET_KEY     = 3'd2,
      REG_HEADER_VERSION = 3'd3,
      REG_HEADER_SIZE    = 3'd4,
      REG_LEAD_CHECK     = 3'd5,
      REG_TRAIL_CHECK    = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_TYPE_ENCODE   = 2'd0,
      MODE_TYPE_DECODE   = 2'd1,
      MODE_OFFSET_ENCODE = 2'd2,
      MODE_OFFSET_DECODE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_VERSION        = 3'd1,
      STATUS_TYPE_ZERO      = 3'd2,
      STATUS_SIZE_TOO_BIG   = 3'd3,
      STATUS_CHECKS_DIFFER  = 3'd4,
      STATUS_CHECKSUM_WRONG = 3'd5
   } status_type;

   localparam int unsigned CTR_W      = 20;
   localparam int unsigned KEY_TYPE_W = 21;
   localparam logic [31:0] VERSION_BASE = 32'd20040308;
   localparam logic [31:0] MAX_BYTES    = 32'd1048576;

   typedef struct packed {
      mode_type                mode;
      logic [KEY_TYPE_W-1:0]   key_type;
      logic [7:0]              offset_key;
      logic [31:0]             header_version;
      logic [31:0]             header_size;
      logic [7:0]              lead_check;
      logic [7:0]              trail_check;
   } cfg_type;

endpackage

// ===== hw/rtl/isc_csr.sv =====
module isc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output isc_pkg::cfg_type      cfg
);
   import isc_pkg::*;

   cfg_type       cfg_ff;
   logic          write_en;
   reg_index_type reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[4:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_TYPE_ENCODE;
         cfg_ff.key_type       <= KEY_TYPE_W'(1);
         cfg_ff.offset_key     <= 8'd0;
         cfg_ff.header_version <= 32'd0;
         cfg_ff.header_size    <= 32'd0;
         cfg_ff.lead_check     <= 8'd0;
         cfg_ff.trail_check    <= 8'd0;
      end else if (write_en) begin
         case (reg_sel)
            REG_MODE:           cfg_ff.mode           <= mode_type'(csr_pwdata[1:0]);
            REG_KEY_TYPE:       cfg_ff.key_type       <= csr_pwdata[KEY_TYPE_W-1:0];
            REG_OFFSET_KEY:     cfg_ff.offset_key     <= csr_pwdata[7:0];
            REG_HEADER_VERSION: cfg_ff.header_version <= csr_pwdata;
            REG_HEADER_SIZE:    cfg_ff.header_size    <= csr_pwdata;
            REG_LEAD_CHECK:     cfg_ff.lead_check     <= csr_pwdata[7:0];
            REG_TRAIL_CHECK:    cfg_ff.trail_check    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MODE:           csr_prdata = {30'd0, cfg_ff.mode};
         REG_KEY_TYPE:       csr_prdata = {{(32-KEY_TYPE_W){1'b0}}, cfg_ff.key_type};
         REG_OFFSET_KEY:     csr_prdata = {24'd0, cfg_ff.offset_key};
         REG_HEADER_VERSION: csr_prdata = cfg_ff.header_version;
         REG_HEADER_SIZE:    csr_prdata = cfg_ff.header_size;
         REG_LEAD_CHECK:     csr_prdata = {24'd0, cfg_ff.lead_check};
         REG_TRAIL_CHECK:    csr_prdata = {24'd0, cfg_ff.trail_check};
         default:            csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== hw/rtl/isc_check.sv =====
module isc_check (
   input  isc_pkg::cfg_type     cfg,
   input  logic [7:0]           checksum,
   output isc_pkg::status_type  status
);
   import isc_pkg::*;

   logic [31:0] expect_version;

   // Header version must match the base plus type plus size, wrapped to 32 bits.
   assign expect_version = VERSION_BASE + {{(32-KEY_TYPE_W){1'b0}}, cfg.key_type}
                           + cfg.header_size;

   always_comb begin
      if (cfg.header_version != expect_version) begin
         status = STATUS_VERSION;
      end else if (cfg.key_type == '0) begin
         status = STATUS_TYPE_ZERO;
      end else if (cfg.header_size > MAX_BYTES) begin
         status = STATUS_SIZE_TOO_BIG;
      end else if (cfg.lead_check != cfg.trail_check) begin
         status = STATUS_CHECKS_DIFFER;
      end else if (cfg.lead_check != checksum) begin
         status = STATUS_CHECKSUM_WRONG;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

// ===== hw/rtl/isc_core.sv =====
module isc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  isc_pkg::cfg_type     cfg,
   input  logic                 advance,
   input  logic [7:0]           data_byte,
   input  logic                 has_byte,
   input  logic                 last_item,
   output logic [7:0]           out_byte,
   output logic [7:0]           checksum,
   output logic [2:0]           status
);
   import isc_pkg::*;

   logic [CTR_W-1:0]      byte_index_ff, byte_index_in;
   logic [CTR_W-1:0]      period_phase_ff, period_phase_in;
   logic [7:0]            running_sum_ff, running_sum_in;

   logic                  typed;
   logic                  decode;
   logic [7:0]            extra;
   logic [7:0]            key;
   logic [7:0]            res;
   logic [7:0]            scr;
   logic [7:0]            sum_next;
   logic [KEY_TYPE_W-1:0] phase_inc;
   logic [7:0]            start;
   logic [7:0]            chk;
   status_type            check_status;

   assign typed  = (cfg.mode == MODE_TYPE_ENCODE) || (cfg.mode == MODE_TYPE_DECODE);
   assign decode = (cfg.mode == MODE_TYPE_DECODE) || (cfg.mode == MODE_OFFSET_DECODE);

   // Type-keyed modes add the type once per period, offset modes add a fixed key.
   always_comb begin
      if (typed) begin
         extra = (period_phase_ff == '0) ? cfg.key_type[7:0] : 8'd0;
      end else begin
         extra = cfg.offset_key;
      end
   end

   assign key      = byte_index_ff[7:0] + extra;
   assign res      = decode ? (data_byte - key) : (data_byte + key);
   assign scr      = decode ? data_byte : res;
   assign sum_next = has_byte ? (running_sum_ff + scr) : running_sum_ff;
   assign phase_inc = {1'b0, period_phase_ff} + KEY_TYPE_W'(1);
   assign start    = typed ? cfg.key_type[7:0] : 8'd0;
   assign chk      = start + sum_next;

   isc_check u_check (
      .cfg      (cfg),
      .checksum (chk),
      .status   (check_status)
   );

   always_comb begin
      byte_index_in   = byte_index_ff;
      period_phase_in = period_phase_ff;
      running_sum_in  = sum_next;
      if (has_byte) begin
         byte_index_in = byte_index_ff + CTR_W'(1);
         if ((cfg.key_type == '0) || (phase_inc >= cfg.key_type)) begin
            period_phase_in = '0;
         end else begin
            period_phase_in = phase_inc[CTR_W-1:0];
         end
      end
      if (last_item) begin
         byte_index_in   = '0;
         period_phase_in = '0;
         running_sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= '0;
         period_phase_ff <= '0;
         running_sum_ff  <= '0;
      end else if (advance) begin
         byte_index_ff   <= byte_index_in;
         period_phase_ff <= period_phase_in;
         running_sum_ff  <= running_sum_in;
      end
   end

   assign out_byte = has_byte ? res : 8'd0;
   assign checksum = last_item ? chk : 8'd0;
   assign status   = (last_item && (cfg.mode == MODE_TYPE_DECODE)) ? check_status
                                                                   : STATUS_OK;

endmodule

// ===== hw/rtl/index_keyed_byte_scrambler_unit.sv =====
// Index-keyed byte scrambler with an 8-bit additive checksum.
//
// Input words arrive on the req_ stream: tdata carries the byte, tuser says
// whether the byte is present and tlast ends the stream. Every accepted word
// produces exactly one result word on the rsp_ stream, carrying the
// transformed byte, the final checksum and the header check status.
// Mode, keys and header words are set through the csr_ port. The user must set
// them only while the stream is idle; the block itself does not enforce this.
//
// Each word first lands in an input register; combinational logic computes
// the key, the scrambled byte and the checksum into the result register.
// A word leaves the input register once the result register is free and is then
// shown on rsp_. Throughput is one word per cycle unless rsp_ stalls, bounded
// by the update of the byte index, period phase and running sum.
//
// Reset clears the counters, empties both registers and loads the register
// defaults. When the receiver stalls, the result register holds its word and
// the input register can still take one more word; after that req_tready
// drops until the result is taken.
module index_keyed_byte_scrambler_unit (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // last_item
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [15:8] checksum, [18:16] status
   output logic        rsp_tuser,   // [0] out_valid
   output logic        rsp_tlast,   // finished
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import isc_pkg::*;

   cfg_type     cfg;

   // Input register.
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_has_ff;
   logic        in_last_ff;

   // Result register.
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff,  out_byte_in;
   logic [7:0]  out_sum_ff,   out_sum_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic        out_has_ff;
   logic        out_last_ff;

   logic        out_free;
   logic        advance;
   logic        req_take;

   isc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The result register frees up when it is empty or its word is taken,
   // and the input register moves on whenever the result register is free.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   isc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .has_byte  (in_has_ff),
      .last_item (in_last_ff),
      .out_byte  (out_byte_in),
      .checksum  (out_sum_in),
      .status    (out_status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_has_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff   <= out_byte_in;
         out_sum_ff    <= out_sum_in;
         out_status_ff <= out_status_in;
         out_has_ff    <= in_has_ff;
         out_last_ff   <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_status_ff, out_sum_ff, out_byte_ff};
   assign rsp_tuser  = out_has_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import isc_pkg::*;

   // Fields of one input word and of one result word.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_item;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       finished;
      logic [7:0] checksum;
      status_type status;
   } rsp_word_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 900;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] has_byte
   logic        req_tlast = 1'b0;    // last_item
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] out_byte, [15:8] checksum, [18:16] status
   logic        rsp_tuser;           // [0] out_valid
   logic        rsp_tlast;           // finished
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   index_keyed_byte_scrambler_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Register mirror and the scrambler state as the block should hold them.
   cfg_type     cfg_mirror;
   logic [19:0] pred_index;
   logic [19:0] pred_phase;
   logic [7:0]  pred_sum;

   req_word_type   pending_words[$];
   rsp_word_type   predicted_words[$];
   req_word_type   next_word;
   rsp_word_type   oldest_word;

   int          words_queued  = 0;
   int          words_taken   = 0;
   int          results_taken = 0;
   int          mismatch_count = 0;
   int          cycle_count   = 0;
   int          send_gap      = 0;
   int          recv_stall    = 0;
   bit          req_taken     = 1'b0;
   bit          rsp_taken     = 1'b0;
   bit          calm_sender   = 1'b0;
   bit          calm_receiver = 1'b0;

   function automatic status_type header_status(logic [7:0] chk);
      logic [31:0] want_version;
      want_version = VERSION_BASE + {11'b0, cfg_mirror.key_type} + cfg_mirror.header_size;
      if (cfg_mirror.header_version != want_version) return STATUS_VERSION;
      if (cfg_mirror.key_type == '0) return STATUS_TYPE_ZERO;
      if (cfg_mirror.header_size > MAX_BYTES) return STATUS_SIZE_TOO_BIG;
      if (cfg_mirror.lead_check != cfg_mirror.trail_check) return STATUS_CHECKS_DIFFER;
      if (cfg_mirror.lead_check != chk) return STATUS_CHECKSUM_WRONG;
      return STATUS_OK;
   endfunction

   // Computes the result of one accepted word and advances the mirrored state.
   function automatic rsp_word_type predict_scramble(req_word_type w);
      rsp_word_type r;
      logic [7:0]  key;
      logic [7:0]  scrambled;
      logic [20:0] next_phase;
      logic        typed;
      logic        decode;
      r = '0;
      typed  = (cfg_mirror.mode == MODE_TYPE_ENCODE) || (cfg_mirror.mode == MODE_TYPE_DECODE);
      decode = (cfg_mirror.mode == MODE_TYPE_DECODE) || (cfg_mirror.mode == MODE_OFFSET_DECODE);
      if (w.has_byte) begin
         key = pred_index[7:0];
         if (typed) begin
            // The type addend lands only on the first byte of each period.
            if (pred_phase == '0) key = key + cfg_mirror.key_type[7:0];
         end else begin
            key = key + cfg_mirror.offset_key;
         end
         if (decode) begin
            r.out_byte = w.data_byte - key;
            scrambled  = w.data_byte;
         end else begin
            r.out_byte = w.data_byte + key;
            scrambled  = r.out_byte;
         end
         r.out_valid = 1'b1;
         pred_sum    = pred_sum + scrambled;
         pred_index  = pred_index + 20'd1;
         next_phase  = {1'b0, pred_phase} + 21'd1;
         if (cfg_mirror.key_type == '0 || next_phase >= cfg_mirror.key_type) next_phase = '0;
         pred_phase  = next_phase[19:0];
      end
      if (w.last_item) begin
         r.finished = 1'b1;
         r.checksum = (typed ? cfg_mirror.key_type[7:0] : 8'd0) + pred_sum;
         if (cfg_mirror.mode == MODE_TYPE_DECODE) r.status = header_status(r.checksum);
         pred_index = '0;
         pred_phase = '0;
         pred_sum   = '0;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Acceptance, prediction and result checking all happen at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted_words.push_back(predict_scramble({req_tdata, req_tuser, req_tlast}));
            req_taken = 1'b1;
            words_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            results_taken++;
            if (predicted_words.size() == 0) begin
               $error("result word 0x%0h arrived with no word outstanding", rsp_tdata);
               mismatch_count++;
            end else begin
               oldest_word = predicted_words.pop_front();
               check_field("out_byte", oldest_word.out_byte, rsp_tdata[7:0]);
               check_field("out_valid", {7'b0, oldest_word.out_valid}, {7'b0, rsp_tuser});
               check_field("finished", {7'b0, oldest_word.finished}, {7'b0, rsp_tlast});
               check_field("checksum", oldest_word.checksum, rsp_tdata[15:8]);
               check_field("status", {5'b0, oldest_word.status}, {5'b0, rsp_tdata[18:16]});
            end
         end
      end
   end

   // Sender: holds a word until it is taken, then waits its drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_tdata  <= next_word.data_byte;
            req_tuser  <= next_word.has_byte;
            req_tlast  <= next_word.last_item;
            req_tvalid <= 1'b1;
            send_gap = calm_sender ? 0 : $urandom_range(0, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: after each result it takes, stalls for a drawn number of cycles.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            recv_stall = calm_receiver ? 0 : $urandom_range(0, 6);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_word(logic [7:0] data, logic has, logic last);
      pending_words.push_back('{data_byte: data, has_byte: has, last_item: last});
      words_queued++;
   endtask

   // Returns at a falling edge once every queued word has been taken and answered.
   task automatic wait_drained();
      @(negedge clock);
      while (!(words_taken == words_queued && results_taken == words_taken))
         @(negedge clock);
   endtask

   // Called at a falling edge; returns at a falling edge with the bus still selected,
   // so that back-to-back writes never assign the same signal twice in one step.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      case (idx)
         REG_MODE:           cfg_mirror.mode = mode_type'(value[1:0]);
         REG_KEY_TYPE:       cfg_mirror.key_type = value[KEY_TYPE_W-1:0];
         REG_OFFSET_KEY:     cfg_mirror.offset_key = value[7:0];
         REG_HEADER_VERSION: cfg_mirror.header_version = value;
         REG_HEADER_SIZE:    cfg_mirror.header_size = value;
         REG_LEAD_CHECK:     cfg_mirror.lead_check = value[7:0];
         REG_TRAIL_CHECK:    cfg_mirror.trail_check = value[7:0];
         default: ;
      endcase
   endtask

   // Waits for the block to go idle, lets the pipeline settle, then loads every register.
   task automatic load_settings(mode_type m, logic [20:0] kt, logic [7:0] ofs,
                                logic [31:0] hv, logic [31:0] hs,
                                logic [7:0] lc, logic [7:0] tc);
      wait_drained();
      repeat (3) @(negedge clock);
      csr_write(REG_MODE, {30'b0, m});
      csr_write(REG_KEY_TYPE, {11'b0, kt});
      csr_write(REG_OFFSET_KEY, {24'b0, ofs});
      csr_write(REG_HEADER_VERSION, hv);
      csr_write(REG_HEADER_SIZE, hs);
      csr_write(REG_LEAD_CHECK, {24'b0, lc});
      csr_write(REG_TRAIL_CHECK, {24'b0, tc});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One random setting followed by a few streams. In type decode most streams end
   // on a byte chosen so that the checksum meets the stored check.
   task automatic random_phase();
      mode_type    m;
      logic [20:0] kt;
      logic [31:0] hs;
      logic [31:0] hv;
      logic [7:0]  lc;
      logic [7:0]  tc;
      logic [7:0]  b;
      logic [7:0]  sum_in;
      int          n_streams;
      int          len;
      m = mode_type'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0:       kt = '0;
         1:       kt = 21'd1;
         2:       kt = 21'd1048576;
         3:       kt = 21'($urandom_range(254, 258));
         4:       kt = 21'($urandom_range(0, 1048576));
         default: kt = 21'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 7))
         0:       hs = $urandom;
         1:       hs = MAX_BYTES;
         2:       hs = MAX_BYTES + 32'd1;
         default: hs = $urandom_range(0, 4096);
      endcase
      hv = ($urandom_range(0, 5) == 0) ? $urandom : VERSION_BASE + {11'b0, kt} + hs;
      lc = 8'($urandom);
      tc = ($urandom_range(0, 5) == 0) ? 8'($urandom) : lc;
      calm_sender   = ($urandom_range(0, 3) == 0);
      calm_receiver = ($urandom_range(0, 3) == 0);
      load_settings(m, kt, 8'($urandom), hv, hs, lc, tc);
      // A stream left open by the last phase carries its sum over.
      sum_in = pred_sum;
      n_streams = $urandom_range(1, 4);
      for (int s = 0; s < n_streams; s++) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 320) : $urandom_range(0, 24);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) push_word(8'($urandom), 1'b0, 1'b0);
            b = 8'($urandom);
            push_word(b, 1'b1, 1'b0);
            sum_in = sum_in + b;
         end
         if (s == n_streams - 1 && $urandom_range(0, 7) == 0) begin
            // Leave the stream open across the next register change.
         end else if ($urandom_range(0, 5) == 0) begin
            push_word(8'($urandom), 1'b0, 1'b1);
            sum_in = '0;
         end else begin
            if (m == MODE_TYPE_DECODE && $urandom_range(0, 3) != 0) b = lc - kt[7:0] - sum_in;
            else b = 8'($urandom);
            push_word(b, 1'b1, 1'b1);
            sum_in = '0;
         end
         // Now and then the sender holds back until every result is in.
         if ($urandom_range(0, 5) == 0) wait_drained();
      end
   endtask

   initial begin
      cfg_mirror.mode           = MODE_TYPE_ENCODE;
      cfg_mirror.key_type       = 21'd1;
      cfg_mirror.offset_key     = 8'd0;
      cfg_mirror.header_version = 32'd0;
      cfg_mirror.header_size    = 32'd0;
      cfg_mirror.lead_check     = 8'd0;
      cfg_mirror.trail_check    = 8'd0;
      pred_index = '0;
      pred_phase = '0;
      pred_sum   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults after reset: byte extremes, an empty word, then an empty finish.
      push_word(8'h00, 1'b1, 1'b0);
      push_word(8'hFF, 1'b1, 1'b0);
      push_word(8'h5A, 1'b0, 1'b0);
      push_word(8'hFF, 1'b1, 1'b1);
      push_word(8'h00, 1'b0, 1'b1);

      // Offset schemes with the largest and a small offset.
      load_settings(MODE_OFFSET_ENCODE, 21'd1, 8'hFF, 32'd0, 32'd0, 8'd0, 8'd0);
      push_word(8'h80, 1'b1, 1'b0);
      push_word(8'hFF, 1'b1, 1'b1);
      load_settings(MODE_OFFSET_DECODE, 21'd5, 8'h01, 32'd0, 32'd0, 8'd0, 8'd0);
      push_word(8'h00, 1'b1, 1'b0);
      push_word(8'h00, 1'b0, 1'b1);

      // Type zero in encode: no extra addend and the phase never moves.
      load_settings(MODE_TYPE_ENCODE, 21'd0, 8'd0, 32'd0, 32'd0, 8'd0, 8'd0);
      push_word(8'h10, 1'b1, 1'b0);
      push_word(8'h20, 1'b1, 1'b1);

      // Type decode, failing header tests: type zero, version, size, checks, checksum.
      load_settings(MODE_TYPE_DECODE, 21'd0, 8'd0, VERSION_BASE + 32'd16, 32'd16, 8'd0, 8'd0);
      push_word(8'h33, 1'b1, 1'b1);
      load_settings(MODE_TYPE_DECODE, 21'd3, 8'd0, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd0);
      push_word(8'h01, 1'b1, 1'b1);
      load_settings(MODE_TYPE_DECODE, 21'd3, 8'd0, VERSION_BASE + 32'd3 + MAX_BYTES + 32'd1,
                    MAX_BYTES + 32'd1, 8'd0, 8'd0);
      push_word(8'h02, 1'b1, 1'b1);
      load_settings(MODE_TYPE_DECODE, 21'd3, 8'd0, VERSION_BASE + 32'd3 + MAX_BYTES,
                    MAX_BYTES, 8'h00, 8'hFF);
      push_word(8'h03, 1'b1, 1'b1);
      load_settings(MODE_TYPE_DECODE, 21'd3, 8'd0, VERSION_BASE + 32'd3, 32'd0, 8'h07, 8'h07);
      push_word(8'h00, 1'b1, 1'b1);

      // A clean decode whose four bytes span a phase wrap; the checksum is 3 + 0xA0.
      load_settings(MODE_TYPE_DECODE, 21'd3, 8'd0, VERSION_BASE + 32'd3, 32'd0, 8'hA3, 8'hA3);
      push_word(8'h10, 1'b1, 1'b0);
      push_word(8'h20, 1'b1, 1'b0);
      push_word(8'h30, 1'b1, 1'b0);
      push_word(8'h40, 1'b1, 1'b1);

      // Largest type with the largest size word: the version sum wraps, the size fails.
      load_settings(MODE_TYPE_DECODE, 21'd1048576, 8'd0, VERSION_BASE + 32'h000F_FFFF,
                    32'hFFFF_FFFF, 8'hFF, 8'hFF);
      push_word(8'hFF, 1'b1, 1'b1);

      while (words_queued < RANDOM_WORDS + 21) random_phase();

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && predicted_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
